// ===== hdl/sfr_pkg.sv =====
package sfr_pkg;

  // fixed field widths
  localparam int DATA_W   = 8;
  localparam int CRC_W    = 16;
  localparam int FILL_W   = 7;
  localparam int INDEX_W  = 6;
  localparam int ADDR_W   = 5;
  localparam int PDATA_W  = 32;

  // bit-serial crc update
  localparam int CRC_STEPS = 8;
  localparam int CNT_W     = 3;

  // buffer size default
  localparam int MAX_PAYLOAD_DEF = 64;

  // register reset values
  localparam logic             CRC_ENABLE_RST  = 1'b1;
  localparam logic [DATA_W-1:0] HEAD_FIRST_RST  = 8'hAA;
  localparam logic [DATA_W-1:0] HEAD_SECOND_RST = 8'h55;
  localparam logic [DATA_W-1:0] TAIL_FIRST_RST  = 8'h55;
  localparam logic [DATA_W-1:0] TAIL_SECOND_RST = 8'hAA;
  localparam logic [CRC_W-1:0]  CRC_POLY_RST    = 16'hA001;
  localparam logic [CRC_W-1:0]  CRC_START_RST   = 16'hFFFF;

  // register indexes
  typedef enum logic [2:0] {
    REG_CRC_ENABLE  = 3'd0,
    REG_HEAD_FIRST  = 3'd1,
    REG_HEAD_SECOND = 3'd2,
    REG_TAIL_FIRST  = 3'd3,
    REG_TAIL_SECOND = 3'd4,
    REG_CRC_POLY    = 3'd5,
    REG_CRC_START   = 3'd6
  } reg_idx_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC     = 2'd1,
    ST_TRAILER = 2'd2,
    ST_LENGTH  = 2'd3
  } status_t;

  typedef struct packed {
    logic              crc_enable;
    logic [DATA_W-1:0] head_first;
    logic [DATA_W-1:0] head_second;
    logic [DATA_W-1:0] tail_first;
    logic [DATA_W-1:0] tail_second;
    logic [CRC_W-1:0]  crc_poly;
    logic [CRC_W-1:0]  crc_start;
  } sfr_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic    load_tag;
    logic    load_len;
    logic    store_data;
    logic    crc_shift;
    logic    load_crc_lo;
    logic    load_crc_hi;
    logic    run_start;
    logic    rd_en;
    logic    out_post;
    logic    out_data;
    logic    idx_inc;
    status_t post_status;
  } sfr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic eq_head_first;
    logic eq_head_second;
    logic eq_tail_first;
    logic eq_tail_second;
    logic len_zero;
    logic len_over;
    logic fill_last;
    logic crc_ok;
    logic held_zero;
    logic run_last;
    logic out_free;
  } sfr_stat_t;

endpackage

// ===== hdl/sfr_ram.sv =====
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/sfr_ctrl.sv =====
module sfr_ctrl
  import sfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sfr_stat_t stat,
  output sfr_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CRC,
    S_POST,
    S_READ,
    S_LOAD
  } state_t;

  typedef enum logic [3:0] {
    PH_HEAD0,
    PH_HEAD1,
    PH_TAG,
    PH_LEN,
    PH_DATA,
    PH_CRCL,
    PH_CRCH,
    PH_TAIL0,
    PH_TAIL1
  } phase_t;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CRC_STEPS - 1);

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  status_t           post_status_r, post_status_nxt;
  logic              in_fire;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    cnt_nxt         = cnt_r;
    post_status_nxt = post_status_r;
    cmd             = '0;
    cmd.post_status = post_status_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (phase_r)
            PH_HEAD0: begin
              if (stat.eq_head_first) phase_nxt = PH_HEAD1;
            end
            PH_HEAD1: begin
              phase_nxt = stat.eq_head_second ? PH_TAG : PH_HEAD0;
            end
            PH_TAG: begin
              cmd.load_tag = 1'b1;
              phase_nxt    = PH_LEN;
            end
            PH_LEN: begin
              cmd.load_len = 1'b1;
              if (stat.len_over) begin
                post_status_nxt = ST_LENGTH;
                state_nxt       = S_POST;
                phase_nxt       = PH_HEAD0;
              end else begin
                phase_nxt = stat.len_zero ? PH_CRCL : PH_DATA;
              end
            end
            PH_DATA: begin
              cmd.store_data = 1'b1;
              cnt_nxt        = '0;
              state_nxt      = S_CRC;
              if (stat.fill_last) phase_nxt = PH_CRCL;
            end
            PH_CRCL: begin
              cmd.load_crc_lo = 1'b1;
              phase_nxt       = PH_CRCH;
            end
            PH_CRCH: begin
              cmd.load_crc_hi = 1'b1;
              phase_nxt       = PH_TAIL0;
            end
            PH_TAIL0: begin
              if (stat.eq_tail_first) begin
                phase_nxt = PH_TAIL1;
              end else begin
                post_status_nxt = ST_TRAILER;
                state_nxt       = S_POST;
                phase_nxt       = PH_HEAD0;
              end
            end
            PH_TAIL1: begin
              phase_nxt = PH_HEAD0;
              if (!stat.eq_tail_second) begin
                post_status_nxt = ST_TRAILER;
                state_nxt       = S_POST;
              end else if (!stat.crc_ok) begin
                post_status_nxt = ST_CRC;
                state_nxt       = S_POST;
              end else if (stat.held_zero) begin
                post_status_nxt = ST_OK;
                state_nxt       = S_POST;
              end else begin
                cmd.run_start = 1'b1;
                state_nxt     = S_READ;
              end
            end
            default: phase_nxt = PH_HEAD0;
          endcase
        end
      end
      // one crc bit per cycle
      S_CRC: begin
        cmd.crc_shift = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) state_nxt = S_IDLE;
      end
      // single result: error or empty frame
      S_POST: begin
        if (stat.out_free) begin
          cmd.out_post = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      // payload run from the buffer
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (stat.out_free) begin
          cmd.out_data = 1'b1;
          if (stat.run_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_READ;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      phase_r       <= PH_HEAD0;
      cnt_r         <= '0;
      post_status_r <= ST_OK;
    end else begin
      state_r       <= state_nxt;
      phase_r       <= phase_nxt;
      cnt_r         <= cnt_nxt;
      post_status_r <= post_status_nxt;
    end
  end

`ifndef SYNTHESIS
  // crc shifting returns to idle after the last step
  a_crc_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CRC && cnt_r == CNT_LAST) |=> (state_r == S_IDLE))
    else $error("crc shift did not finish after the last step");

  // a payload byte always launches a crc pass
  a_store_crc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store_data |=> (state_r == S_CRC && cnt_r == '0))
    else $error("payload byte not followed by crc pass");

  // a read is always followed by its load state
  a_read_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> (state_r == S_LOAD))
    else $error("buffer read not followed by load");
`endif

endmodule

// ===== hdl/sfr_dp.sv =====
module sfr_dp
  import sfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sfr_cfg_t           cfg,
  input  logic [DATA_W-1:0]  in_rx_byte,
  input  sfr_cmd_t           cmd,
  output sfr_stat_t          stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DATA_W-1:0]  out_frame_tag,
  output logic [DATA_W-1:0]  out_payload_count,
  output logic [INDEX_W-1:0] out_byte_index,
  output logic [DATA_W-1:0]  out_payload_byte,
  output logic               out_has_byte,
  output logic               out_last,
  output logic [1:0]         out_status
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [DATA_W-1:0] MAX_LEN = DATA_W'(MAX_PAYLOAD);

  logic [DATA_W-1:0]  tag_r;
  logic [DATA_W-1:0]  len_r;
  logic [FILL_W-1:0]  fill_r;
  logic [CRC_W-1:0]   crc_r;
  logic [CRC_W-1:0]   rcrc_r;
  logic [INDEX_W-1:0] idx_r;
  logic               out_valid_r;
  logic [DATA_W-1:0]  out_tag_r, out_count_r, out_data_r;
  logic [INDEX_W-1:0] out_index_r;
  logic               out_has_r, out_last_r;
  status_t            out_status_r;
  logic [DATA_W-1:0]  ram_rd_data;
  logic [CRC_W-1:0]   crc_step;
  logic               run_last;

  // payload buffer
  sfr_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_PAYLOAD)
  ) u_ram (
    .clk    (clk),
    .wr_en  (cmd.store_data),
    .wr_addr(fill_r[AW-1:0]),
    .wr_data(in_rx_byte),
    .rd_en  (cmd.rd_en),
    .rd_addr(idx_r[AW-1:0]),
    .rd_data(ram_rd_data)
  );

  // one reflected crc step
  assign crc_step = crc_r[0] ? ((crc_r >> 1) ^ cfg.crc_poly) : (crc_r >> 1);

  assign run_last = ((DATA_W'(idx_r) + 8'd1) == len_r);

  // status to controller
  always_comb begin
    stat.eq_head_first  = (in_rx_byte == cfg.head_first);
    stat.eq_head_second = (in_rx_byte == cfg.head_second);
    stat.eq_tail_first  = (in_rx_byte == cfg.tail_first);
    stat.eq_tail_second = (in_rx_byte == cfg.tail_second);
    stat.len_zero       = (in_rx_byte == '0);
    stat.len_over       = (in_rx_byte > MAX_LEN);
    stat.fill_last      = ((DATA_W'(fill_r) + 8'd1) >= len_r);
    stat.crc_ok         = !cfg.crc_enable || (crc_r == rcrc_r);
    stat.held_zero      = (len_r == '0);
    stat.run_last       = run_last;
    stat.out_free       = !out_valid_r || out_ready;
  end

  // frame registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r  <= '0;
      len_r  <= '0;
      fill_r <= '0;
      crc_r  <= CRC_START_RST;
      rcrc_r <= '0;
      idx_r  <= '0;
    end else begin
      if (cmd.load_tag) tag_r <= in_rx_byte;
      if (cmd.load_len) begin
        len_r  <= in_rx_byte;
        fill_r <= '0;
        crc_r  <= cfg.crc_start;
      end
      if (cmd.store_data) begin
        fill_r <= fill_r + 1'b1;
        crc_r  <= crc_r ^ CRC_W'(in_rx_byte);
      end
      if (cmd.crc_shift) crc_r <= crc_step;
      if (cmd.load_crc_lo) rcrc_r <= CRC_W'(in_rx_byte);
      if (cmd.load_crc_hi) rcrc_r <= {in_rx_byte, rcrc_r[DATA_W-1:0]};
      if (cmd.run_start) idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_post || cmd.out_data) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.out_post) begin
      out_tag_r    <= tag_r;
      out_count_r  <= len_r;
      out_index_r  <= '0;
      out_data_r   <= '0;
      out_has_r    <= 1'b0;
      out_last_r   <= 1'b1;
      out_status_r <= cmd.post_status;
    end else if (cmd.out_data) begin
      out_tag_r    <= tag_r;
      out_count_r  <= len_r;
      out_index_r  <= idx_r;
      out_data_r   <= ram_rd_data;
      out_has_r    <= 1'b1;
      out_last_r   <= run_last;
      out_status_r <= ST_OK;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_tag     = out_tag_r;
  assign out_payload_count = out_count_r;
  assign out_byte_index    = out_index_r;
  assign out_payload_byte  = out_data_r;
  assign out_has_byte      = out_has_r;
  assign out_last          = out_last_r;
  assign out_status        = out_status_r;

`ifndef SYNTHESIS
  // the output slot is only loaded when free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_post || cmd.out_data) |-> (!out_valid_r || out_ready))
    else $error("output register overwritten while full");

  // payload writes stay inside the buffer and the frame length
  a_store_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store_data |-> (DATA_W'(fill_r) < len_r && DATA_W'(fill_r) < MAX_LEN))
    else $error("payload write beyond frame length");

  // run reads only cover the stored payload
  a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (DATA_W'(idx_r) < len_r && DATA_W'(idx_r) < MAX_LEN))
    else $error("payload read beyond frame length");
`endif

endmodule

// ===== hdl/serial_frame_receiver.sv =====
// channel   direction  handshake            payload
// in_       input      in_valid/in_ready    in_rx_byte
// out_      output     out_valid/out_ready  frame_tag payload_count byte_index
//                                           payload_byte has_byte last status
// cfg       apb        psel/penable/pready  paddr pwdata prdata
//
// header, length, crc and trailer bytes are taken in the idle state; after a
// payload byte, input waits while the bit-serial crc unit steps once a cycle
// a good frame emits its run one result at a time through the buffer's
// registered read port, a read and a load per result; no input during the run
// synchronous active-low reset; no clearing pass, the buffer needs none
// a stalled output holds its register; input is taken again once the slot
// holds the final result of a frame
module serial_frame_receiver
  import sfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [DATA_W-1:0]  in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DATA_W-1:0]  out_frame_tag,
  output logic [DATA_W-1:0]  out_payload_count,
  output logic [INDEX_W-1:0] out_byte_index,
  output logic [DATA_W-1:0]  out_payload_byte,
  output logic               out_has_byte,
  output logic               out_last,
  output logic [1:0]         out_status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  sfr_cfg_t  cfg_r;
  sfr_cmd_t  cmd;
  sfr_stat_t stat;
  logic      wr_en;
  logic      addr_ok;

  assign pready  = 1'b1;
  assign addr_ok = (paddr[1:0] == 2'b00);
  assign wr_en   = psel && penable && pwrite && addr_ok;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crc_enable  <= CRC_ENABLE_RST;
      cfg_r.head_first  <= HEAD_FIRST_RST;
      cfg_r.head_second <= HEAD_SECOND_RST;
      cfg_r.tail_first  <= TAIL_FIRST_RST;
      cfg_r.tail_second <= TAIL_SECOND_RST;
      cfg_r.crc_poly    <= CRC_POLY_RST;
      cfg_r.crc_start   <= CRC_START_RST;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_CRC_ENABLE:  cfg_r.crc_enable  <= pwdata[0];
        REG_HEAD_FIRST:  cfg_r.head_first  <= pwdata[DATA_W-1:0];
        REG_HEAD_SECOND: cfg_r.head_second <= pwdata[DATA_W-1:0];
        REG_TAIL_FIRST:  cfg_r.tail_first  <= pwdata[DATA_W-1:0];
        REG_TAIL_SECOND: cfg_r.tail_second <= pwdata[DATA_W-1:0];
        REG_CRC_POLY:    cfg_r.crc_poly    <= pwdata[CRC_W-1:0];
        REG_CRC_START:   cfg_r.crc_start   <= pwdata[CRC_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    if (addr_ok) begin
      case (paddr[4:2])
        REG_CRC_ENABLE:  prdata = PDATA_W'(cfg_r.crc_enable);
        REG_HEAD_FIRST:  prdata = PDATA_W'(cfg_r.head_first);
        REG_HEAD_SECOND: prdata = PDATA_W'(cfg_r.head_second);
        REG_TAIL_FIRST:  prdata = PDATA_W'(cfg_r.tail_first);
        REG_TAIL_SECOND: prdata = PDATA_W'(cfg_r.tail_second);
        REG_CRC_POLY:    prdata = PDATA_W'(cfg_r.crc_poly);
        REG_CRC_START:   prdata = PDATA_W'(cfg_r.crc_start);
        default:         prdata = '0;
      endcase
    end
  end

  sfr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  sfr_dp #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_rx_byte       (in_rx_byte),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_tag    (out_frame_tag),
    .out_payload_count(out_payload_count),
    .out_byte_index   (out_byte_index),
    .out_payload_byte (out_payload_byte),
    .out_has_byte     (out_has_byte),
    .out_last         (out_last),
    .out_status       (out_status)
  );

endmodule

// ===== test/serial_frame_receiver_test.sv =====
`timescale 1ns / 1ps

module serial_frame_receiver_test;
  import sfr_pkg::*;

  localparam int PAYLOAD_CAP   = MAX_PAYLOAD_DEF;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_CYCLES  = 400;

  // parser position in the byte stream
  typedef enum logic [3:0] {
    SEEK_HEAD0, SEEK_HEAD1, TAKE_TAG, TAKE_LEN, TAKE_DATA,
    TAKE_CRC_LO, TAKE_CRC_HI, TAKE_TAIL0, TAKE_TAIL1
  } rx_phase_t;

  // ways a generated frame can be spoiled
  typedef enum logic [2:0] {
    FLAW_NONE, FLAW_HEAD, FLAW_LONG, FLAW_CRC, FLAW_TAIL0, FLAW_TAIL1
  } flaw_t;

  typedef struct packed {
    logic [DATA_W-1:0]  tag;
    logic [DATA_W-1:0]  count;
    logic [INDEX_W-1:0] index;
    logic [DATA_W-1:0]  data;
    logic               has;
    logic               last;
    status_t            status;
  } frame_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [DATA_W-1:0]  in_rx_byte = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [DATA_W-1:0]  out_frame_tag;
  logic [DATA_W-1:0]  out_payload_count;
  logic [INDEX_W-1:0] out_byte_index;
  logic [DATA_W-1:0]  out_payload_byte;
  logic               out_has_byte;
  logic               out_last;
  logic [1:0]         out_status;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // stimulus and scoreboard state
  logic [DATA_W-1:0] pending_bytes[$];
  logic [DATA_W-1:0] frame_body[$];
  frame_result_t     due_results[$];
  int                queued_count = 0;
  int                failures = 0;
  logic              in_accepted = 1'b0;
  logic              steady = 1'b0;
  logic              stall_wanted = 1'b0;
  logic              stall_done = 1'b0;
  int                stall_left = 0;

  // predictor copy of the registers and the parser
  sfr_cfg_t          rx_cfg = '{crc_enable: CRC_ENABLE_RST, head_first: HEAD_FIRST_RST,
                                head_second: HEAD_SECOND_RST, tail_first: TAIL_FIRST_RST,
                                tail_second: TAIL_SECOND_RST, crc_poly: CRC_POLY_RST,
                                crc_start: CRC_START_RST};
  rx_phase_t         rx_phase = SEEK_HEAD0;
  logic [DATA_W-1:0] rx_tag = '0;
  logic [DATA_W-1:0] rx_len = '0;
  logic [FILL_W-1:0] rx_fill = '0;
  logic [CRC_W-1:0]  rx_crc = CRC_START_RST;
  logic [CRC_W-1:0]  rx_crc_seen = '0;
  logic [DATA_W-1:0] frame_buf[PAYLOAD_CAP];

  serial_frame_receiver u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_tag     (out_frame_tag),
    .out_payload_count (out_payload_count),
    .out_byte_index    (out_byte_index),
    .out_payload_byte  (out_payload_byte),
    .out_has_byte      (out_has_byte),
    .out_last          (out_last),
    .out_status        (out_status),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #10 clk = ~clk;

  // reflected crc-16, one byte
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [DATA_W-1:0] b,
                                                input logic [CRC_W-1:0] poly);
    logic [CRC_W-1:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic idle_roll();
    return !steady && ($urandom_range(0, 99) < 24);
  endfunction

  function automatic void post_result(input logic [INDEX_W-1:0] idx,
                                      input logic [DATA_W-1:0] data,
                                      input logic has, input logic last,
                                      input status_t status);
    frame_result_t r;
    r = '{tag: rx_tag, count: rx_len, index: idx, data: data, has: has, last: last,
          status: status};
    due_results.push_back(r);
  endfunction

  // advance the parser by one received byte
  function automatic void parse_rx_byte(input logic [DATA_W-1:0] b);
    case (rx_phase)
      SEEK_HEAD0: begin
        if (b == rx_cfg.head_first) rx_phase = SEEK_HEAD1;
      end
      SEEK_HEAD1: begin
        rx_phase = (b == rx_cfg.head_second) ? TAKE_TAG : SEEK_HEAD0;
      end
      TAKE_TAG: begin
        rx_tag = b;
        rx_phase = TAKE_LEN;
      end
      TAKE_LEN: begin
        rx_len = b;
        rx_fill = '0;
        rx_crc = rx_cfg.crc_start;
        if (b > PAYLOAD_CAP) begin
          post_result('0, '0, 1'b0, 1'b1, ST_LENGTH);
          rx_phase = SEEK_HEAD0;
        end else begin
          rx_phase = (b == 0) ? TAKE_CRC_LO : TAKE_DATA;
        end
      end
      TAKE_DATA: begin
        if (rx_fill < PAYLOAD_CAP) frame_buf[rx_fill[INDEX_W-1:0]] = b;
        rx_crc = crc_byte(rx_crc, b, rx_cfg.crc_poly);
        rx_fill = rx_fill + 1'b1;
        if (rx_fill >= rx_len) rx_phase = TAKE_CRC_LO;
      end
      TAKE_CRC_LO: begin
        rx_crc_seen = {8'h00, b};
        rx_phase = TAKE_CRC_HI;
      end
      TAKE_CRC_HI: begin
        rx_crc_seen[15:8] = b;
        rx_phase = TAKE_TAIL0;
      end
      TAKE_TAIL0: begin
        if (b == rx_cfg.tail_first) begin
          rx_phase = TAKE_TAIL1;
        end else begin
          post_result('0, '0, 1'b0, 1'b1, ST_TRAILER);
          rx_phase = SEEK_HEAD0;
        end
      end
      TAKE_TAIL1: begin
        rx_phase = SEEK_HEAD0;
        if (b != rx_cfg.tail_second) begin
          post_result('0, '0, 1'b0, 1'b1, ST_TRAILER);
        end else if (rx_cfg.crc_enable && rx_crc != rx_crc_seen) begin
          post_result('0, '0, 1'b0, 1'b1, ST_CRC);
        end else if (rx_len == 0) begin
          post_result('0, '0, 1'b0, 1'b1, ST_OK);
        end else begin
          for (int i = 0; i < rx_len && i < PAYLOAD_CAP; i++) begin
            post_result(INDEX_W'(i), frame_buf[i], 1'b1, (i + 1 == rx_len), ST_OK);
          end
        end
      end
      default: rx_phase = SEEK_HEAD0;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  function automatic void check_result();
    frame_result_t want;
    if (due_results.size() == 0) begin
      $error("result transaction with nothing expected (tag %0h)", out_frame_tag);
      failures++;
    end else begin
      want = due_results.pop_front();
      check_field("frame_tag", want.tag, out_frame_tag);
      check_field("payload_count", want.count, out_payload_count);
      check_field("byte_index", want.index, out_byte_index);
      check_field("payload_byte", want.data, out_payload_byte);
      check_field("has_byte", want.has, out_has_byte);
      check_field("last", want.last, out_last);
      check_field("status", want.status, out_status);
    end
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk) begin
    in_accepted <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) parse_rx_byte(in_rx_byte);
      if (out_valid && out_ready) check_result();
    end
  end

  // byte driver, fed from the pending queue
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_accepted) begin
      // hold the offered byte until taken
    end else if (pending_bytes.size() != 0 && !idle_roll()) begin
      in_valid <= 1'b1;
      in_rx_byte <= pending_bytes.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result receiver with random stalls and one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_wanted && !stall_done && out_valid) begin
      out_ready <= 1'b0;
      stall_left <= STALL_CYCLES;
      stall_done <= 1'b1;
    end else begin
      out_ready <= !idle_roll();
    end
  end

  // register access
  function automatic logic [PDATA_W-1:0] cfg_value(input reg_idx_t r);
    case (r)
      REG_CRC_ENABLE:  return PDATA_W'(rx_cfg.crc_enable);
      REG_HEAD_FIRST:  return PDATA_W'(rx_cfg.head_first);
      REG_HEAD_SECOND: return PDATA_W'(rx_cfg.head_second);
      REG_TAIL_FIRST:  return PDATA_W'(rx_cfg.tail_first);
      REG_TAIL_SECOND: return PDATA_W'(rx_cfg.tail_second);
      REG_CRC_POLY:    return PDATA_W'(rx_cfg.crc_poly);
      default:         return PDATA_W'(rx_cfg.crc_start);
    endcase
  endfunction

  task automatic apb_access(input reg_idx_t r, input logic wr,
                            input logic [PDATA_W-1:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (wr) begin
      case (r)
        REG_CRC_ENABLE:  rx_cfg.crc_enable = v[0];
        REG_HEAD_FIRST:  rx_cfg.head_first = v[7:0];
        REG_HEAD_SECOND: rx_cfg.head_second = v[7:0];
        REG_TAIL_FIRST:  rx_cfg.tail_first = v[7:0];
        REG_TAIL_SECOND: rx_cfg.tail_second = v[7:0];
        REG_CRC_POLY:    rx_cfg.crc_poly = v[15:0];
        default:         rx_cfg.crc_start = v[15:0];
      endcase
    end else if (prdata !== cfg_value(r)) begin
      $error("register %s: expected %0h, got %0h", r.name(), cfg_value(r), prdata);
      failures++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic read_back_all();
    for (int i = REG_CRC_ENABLE; i <= REG_CRC_START; i++) begin
      apb_access(reg_idx_t'(i), 1'b0, '0);
    end
  endtask

  task automatic apply_settings(input logic en, input logic [7:0] h0, input logic [7:0] h1,
                                input logic [7:0] t0, input logic [7:0] t1,
                                input logic [15:0] poly, input logic [15:0] start);
    apb_access(REG_CRC_ENABLE, 1'b1, PDATA_W'(en));
    apb_access(REG_HEAD_FIRST, 1'b1, PDATA_W'(h0));
    apb_access(REG_HEAD_SECOND, 1'b1, PDATA_W'(h1));
    apb_access(REG_TAIL_FIRST, 1'b1, PDATA_W'(t0));
    apb_access(REG_TAIL_SECOND, 1'b1, PDATA_W'(t1));
    apb_access(REG_CRC_POLY, 1'b1, PDATA_W'(poly));
    apb_access(REG_CRC_START, 1'b1, PDATA_W'(start));
    read_back_all();
  endtask

  // frame building
  task automatic send_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    queued_count++;
  endtask

  task automatic fill_body(input int len);
    frame_body.delete();
    for (int i = 0; i < len; i++) frame_body.push_back(8'($urandom_range(0, 255)));
  endtask

  // pick a byte that differs from the one the parser wants
  function automatic logic [7:0] other_than(input logic [7:0] avoid);
    return avoid ^ 8'($urandom_range(1, 255));
  endfunction

  task automatic queue_frame(input logic [7:0] tag, input logic [7:0] len,
                             input flaw_t flaw);
    logic [CRC_W-1:0] crc;
    crc = rx_cfg.crc_start;
    send_byte(rx_cfg.head_first);
    if (flaw == FLAW_HEAD) begin
      send_byte(other_than(rx_cfg.head_second));
      return;
    end
    send_byte(rx_cfg.head_second);
    send_byte(tag);
    send_byte(len);
    if (flaw == FLAW_LONG) return;
    for (int i = 0; i < len; i++) begin
      send_byte(frame_body[i]);
      crc = crc_byte(crc, frame_body[i], rx_cfg.crc_poly);
    end
    if (flaw == FLAW_CRC) crc = crc ^ 16'($urandom_range(1, 65535));
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
    if (flaw == FLAW_TAIL0) begin
      send_byte(other_than(rx_cfg.tail_first));
      return;
    end
    send_byte(rx_cfg.tail_first);
    send_byte((flaw == FLAW_TAIL1) ? other_than(rx_cfg.tail_second) : rx_cfg.tail_second);
  endtask

  // mostly well-formed frames with random content, some noise and damage
  task automatic random_frames(input int target);
    int    start_count;
    int    pick;
    flaw_t flaw;
    logic [7:0] len;
    start_count = queued_count;
    while (queued_count - start_count < target) begin
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end
      pick = $urandom_range(0, 99);
      flaw = (pick < 65) ? FLAW_NONE : (pick < 73) ? FLAW_CRC : (pick < 80) ? FLAW_TAIL0 :
             (pick < 86) ? FLAW_TAIL1 : (pick < 92) ? FLAW_HEAD : FLAW_LONG;
      if (flaw == FLAW_LONG) begin
        len = ($urandom_range(0, 3) == 0) ? 8'(PAYLOAD_CAP + 1) : 8'($urandom_range(66, 255));
      end else begin
        len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(7, 24))
                                          : 8'($urandom_range(0, 6));
        fill_body(len);
      end
      queue_frame(8'($urandom_range(0, 255)), len, flaw);
    end
  endtask

  // wait until every byte is taken and every result seen
  task automatic drain_and_settle();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_valid || due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // main sequence
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    read_back_all();

    // directed: bad second head, oversize, empty frame, crc error, bad trailer
    send_byte(HEAD_FIRST_RST);
    send_byte(8'h00);
    queue_frame(8'hFF, 8'hFF, FLAW_LONG);
    frame_body.delete();
    queue_frame(8'h00, 8'd0, FLAW_NONE);
    frame_body.push_back(8'h00);
    queue_frame(8'h5A, 8'd1, FLAW_CRC);
    queue_frame(8'hA5, 8'd0, FLAW_TAIL0);
    random_frames(16);
    drain_and_settle();

    // crc check off, extreme marker bytes and crc values
    apply_settings(1'b0, 8'h00, 8'hFF, 8'hFF, 8'h00, 16'hFFFF, 16'h0000);
    random_frames(16);
    drain_and_settle();

    // zero polynomial, random markers, no idling on either side
    steady = 1'b1;
    apply_settings(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   16'h0000, 16'hFFFF);
    random_frames(16);
    drain_and_settle();
    steady = 1'b0;

    // opposite marker extremes, random crc settings
    apply_settings(1'b1, 8'hFF, 8'h00, 8'h00, 8'hFF, 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)));
    random_frames(16);
    drain_and_settle();

    // back to defaults: full-size frame under a long receiver hold-off
    apply_settings(CRC_ENABLE_RST, HEAD_FIRST_RST, HEAD_SECOND_RST, TAIL_FIRST_RST,
                   TAIL_SECOND_RST, CRC_POLY_RST, CRC_START_RST);
    stall_wanted = 1'b1;
    fill_body(PAYLOAD_CAP);
    queue_frame(8'($urandom_range(0, 255)), 8'(PAYLOAD_CAP), FLAW_NONE);
    random_frames(16);
    drain_and_settle();

    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
